// ===== rtl/core/penalized_proximal_operator_core_assert.svh =====
// assertion helpers for the proximal operator core
`ifndef PENALIZED_PROXIMAL_OPERATOR_CORE_ASSERT_SVH
`define PENALIZED_PROXIMAL_OPERATOR_CORE_ASSERT_SVH

// consequent checked on the same clock edge
`define PPO_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked on the following clock edge
`define PPO_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ppo_pkg.sv =====
package ppo_pkg;

    // register file layout
    localparam int REG_WIDTH       = 31;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_PENALTY_KIND     = 3'd0,
        CFG_SHRINK_THRESHOLD = 3'd1,
        CFG_RIDGE_AMOUNT     = 3'd2,
        CFG_SCAD_SHAPE       = 3'd3,
        CFG_POSITIVE_ONLY    = 3'd4
    } cfg_index_t;

    typedef enum logic {
        KIND_ELASTIC = 1'b0,
        KIND_SCAD    = 1'b1
    } penalty_kind_t;

    // how the final magnitude is formed
    typedef enum logic [2:0] {
        SEL_PASS,
        SEL_ZERO,
        SEL_SHIFTED,
        SEL_KEEP,
        SEL_RIDGE,
        SEL_SCAD
    } result_sel_t;

    // fixed point
    localparam int FRAC_BITS = 16;
    localparam int DIV_WIDTH = 32;
    localparam int AT_WIDTH  = 2 * REG_WIDTH;

    localparam logic [DIV_WIDTH-1:0] FRAC_ONE        = 32'h0001_0000;
    localparam logic [REG_WIDTH-1:0] SHAPE_MIN_RAW   = 31'd137625;
    localparam logic [REG_WIDTH-1:0] SHAPE_DEFAULT   = 31'd242483;
    localparam logic [REG_WIDTH-1:0] SCAD_DEN_OFFSET = 31'd131072;

endpackage

// ===== rtl/core/penalized_proximal_operator_core.sv =====
// path: stage a, stage b, the one-bit-per-stage divider chain, stage f and the output
//   register lie between the edge that takes start and the edge that raises done
// throughput: one request per clock, back to back; done is a one-cycle strobe per request
//   and the receiver cannot stall, so busy stays low once out of reset
// reset: rst_n (async, active low) clears the pipeline valid bits and resets the config registers;
//   busy is high during reset and drops at the first clock after release
`include "penalized_proximal_operator_core_assert.svh"

module penalized_proximal_operator_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [VALUE_WIDTH-1:0]          coefficient,
    input  logic                                   penalized,
    output logic                                   done,
    output logic signed [VALUE_WIDTH-1:0]          mapped_coefficient,
    input  logic                                   cfg_write,
    input  logic [ppo_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [ppo_pkg::REG_WIDTH-1:0]          cfg_data
);

    localparam int REG_W      = ppo_pkg::REG_WIDTH;
    localparam int DIV_W      = ppo_pkg::DIV_WIDTH;
    localparam int AT_W       = ppo_pkg::AT_WIDTH;
    localparam int FRAC_W     = ppo_pkg::FRAC_BITS;
    localparam int QUOT_WIDTH = (VALUE_WIDTH > REG_W) ? VALUE_WIDTH : REG_W;
    localparam int NUM_WIDTH  = QUOT_WIDTH + DIV_W;
    localparam int AT_HI_W    = AT_W - FRAC_W;
    localparam int CMP_WIDTH  = ((VALUE_WIDTH > AT_HI_W) ? VALUE_WIDTH : AT_HI_W) + 1;
    localparam int SCALE_W    = CMP_WIDTH + FRAC_W;
    localparam int SCAD_NUM_W = AT_W + 1;
    localparam int RIDGE_NUM_W = VALUE_WIDTH + FRAC_W;
    localparam int RESULT_LATENCY = QUOT_WIDTH + 5;

    localparam logic [VALUE_WIDTH-1:0] V_ONE = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};

    // configuration registers
    ppo_pkg::penalty_kind_t penalty_kind_reg;
    logic [REG_W-1:0]       shrink_threshold_reg;
    logic [REG_W-1:0]       ridge_amount_reg;
    logic [REG_W-1:0]       scad_shape_reg;
    logic                   positive_only_reg;
    logic                   busy_reg;
    logic                   busy_next;

    // config-derived constants, refreshed every clock
    logic [REG_W-1:0] shape_eff;
    logic [AT_W-1:0]  scad_at_reg,   scad_at_next;
    logic [REG_W-1:0] scad_den_reg,  scad_den_next;
    logic [DIV_W-1:0] ridge_div_reg, ridge_div_next;
    logic             no_penalty;

    // stage a: sign split
    logic                   accept;
    logic [VALUE_WIDTH-1:0] coef_bits;
    logic                   coef_neg;
    logic                   a_valid_reg, a_valid_next;
    logic [VALUE_WIDTH-1:0] a_value_reg, a_value_next;
    logic                   a_pass_reg,  a_pass_next;
    logic                   a_neg_reg,   a_neg_next;
    logic [VALUE_WIDTH-1:0] a_mag_reg,   a_mag_next;

    // stage b: zone decision
    logic [CMP_WIDTH-1:0]   mag_cmp, thr_cmp, thr2_cmp, at_hi_cmp, shifted_cmp;
    logic [SCALE_W-1:0]     mag_scaled, gap_full;
    logic                   le_thr, le_thr2, le_at_hi;
    logic                   b_valid_reg, b_valid_next;
    ppo_pkg::result_sel_t   b_sel_reg,   b_sel_next;
    logic                   b_neg_reg,   b_neg_next;
    logic [VALUE_WIDTH-1:0] b_base_reg,  b_base_next;
    logic [VALUE_WIDTH-1:0] b_shift_reg, b_shift_next;
    logic [AT_W-1:0]        b_gap_reg,   b_gap_next;

    // divider chain, index 0 is the loaded numerator
    logic [SCAD_NUM_W-1:0]  scad_num;
    logic [RIDGE_NUM_W-1:0] ridge_num;
    logic [NUM_WIDTH-1:0]   div_num;
    logic                   div_valid_reg  [QUOT_WIDTH+1];
    logic                   div_valid_next [QUOT_WIDTH+1];
    ppo_pkg::result_sel_t   div_sel_reg    [QUOT_WIDTH+1];
    ppo_pkg::result_sel_t   div_sel_next   [QUOT_WIDTH+1];
    logic                   div_neg_reg    [QUOT_WIDTH+1];
    logic                   div_neg_next   [QUOT_WIDTH+1];
    logic [VALUE_WIDTH-1:0] div_direct_reg [QUOT_WIDTH+1];
    logic [VALUE_WIDTH-1:0] div_direct_next[QUOT_WIDTH+1];
    logic [DIV_W-1:0]       div_rem_reg    [QUOT_WIDTH+1];
    logic [DIV_W-1:0]       div_rem_next   [QUOT_WIDTH+1];
    logic [QUOT_WIDTH-1:0]  div_bits_reg   [QUOT_WIDTH+1];
    logic [QUOT_WIDTH-1:0]  div_bits_next  [QUOT_WIDTH+1];
    logic [DIV_W-1:0]       last_divisor;

    // stage f: magnitude assembly
    logic [VALUE_WIDTH-1:0] quot;
    logic                   f_valid_reg, f_valid_next;
    logic                   f_pass_reg,  f_pass_next;
    logic                   f_neg_reg,   f_neg_next;
    logic [VALUE_WIDTH-1:0] f_mag_reg,   f_mag_next;

    // output register
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH-1:0] mapped_coefficient_reg, mapped_coefficient_next;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            penalty_kind_reg     <= ppo_pkg::KIND_ELASTIC;
            shrink_threshold_reg <= '0;
            ridge_amount_reg     <= '0;
            scad_shape_reg       <= ppo_pkg::SHAPE_DEFAULT;
            positive_only_reg    <= 1'b0;
            busy_reg             <= 1'b1;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    ppo_pkg::CFG_PENALTY_KIND:
                        penalty_kind_reg <= ppo_pkg::penalty_kind_t'(cfg_data[0]);
                    ppo_pkg::CFG_SHRINK_THRESHOLD: shrink_threshold_reg <= cfg_data;
                    ppo_pkg::CFG_RIDGE_AMOUNT:     ridge_amount_reg     <= cfg_data;
                    ppo_pkg::CFG_SCAD_SHAPE:       scad_shape_reg       <= cfg_data;
                    ppo_pkg::CFG_POSITIVE_ONLY:    positive_only_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // derived constants: effective shape, a*t, scad and ridge divisors, no-penalty flag
    always_comb
    begin
        busy_next      = 1'b0;
        shape_eff      = (scad_shape_reg <= ppo_pkg::SHAPE_MIN_RAW) ? ppo_pkg::SHAPE_DEFAULT
                                                                   : scad_shape_reg;
        scad_at_next   = AT_W'(shape_eff) * AT_W'(shrink_threshold_reg);
        scad_den_next  = shape_eff - ppo_pkg::SCAD_DEN_OFFSET;
        ridge_div_next = DIV_W'(ridge_amount_reg) + ppo_pkg::FRAC_ONE;
        no_penalty     = (shrink_threshold_reg == '0) &&
                         (penalty_kind_reg == ppo_pkg::KIND_SCAD || ridge_amount_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        scad_at_reg   <= scad_at_next;
        scad_den_reg  <= scad_den_next;
        ridge_div_reg <= ridge_div_next;
    end

    // stage a: take the request, split off the sign
    always_comb
    begin
        accept       = start && !busy_reg;
        coef_bits    = coefficient;
        coef_neg     = coef_bits[VALUE_WIDTH-1];
        a_valid_next = accept;
        a_value_next = coef_bits;
        a_pass_next  = !penalized || no_penalty;
        a_neg_next   = coef_neg;
        a_mag_next   = coef_neg ? (~coef_bits + V_ONE) : coef_bits;
    end

    // stage b: compare against the zone bounds, form m - t and a*t - m
    always_comb
    begin
        mag_cmp     = CMP_WIDTH'(a_mag_reg);
        thr_cmp     = CMP_WIDTH'(shrink_threshold_reg);
        thr2_cmp    = CMP_WIDTH'({shrink_threshold_reg, 1'b0});
        at_hi_cmp   = CMP_WIDTH'(scad_at_reg[AT_W-1:FRAC_W]);
        le_thr      = mag_cmp <= thr_cmp;
        le_thr2     = mag_cmp <= thr2_cmp;
        le_at_hi    = mag_cmp <= at_hi_cmp;
        shifted_cmp = mag_cmp - thr_cmp;
        mag_scaled  = {mag_cmp, {FRAC_W{1'b0}}};
        gap_full    = SCALE_W'(scad_at_reg) - mag_scaled;

        b_valid_next = a_valid_reg;
        b_neg_next   = a_neg_reg;
        b_base_next  = a_pass_reg ? a_value_reg : a_mag_reg;
        b_shift_next = shifted_cmp[VALUE_WIDTH-1:0];
        b_gap_next   = gap_full[AT_W-1:0];

        priority if (a_pass_reg)
            b_sel_next = ppo_pkg::SEL_PASS;
        else if (le_thr)
            b_sel_next = ppo_pkg::SEL_ZERO;
        else if (penalty_kind_reg == ppo_pkg::KIND_ELASTIC)
            b_sel_next = ppo_pkg::SEL_RIDGE;
        else if (le_thr2)
            b_sel_next = ppo_pkg::SEL_SHIFTED;
        else if (le_at_hi)
            b_sel_next = ppo_pkg::SEL_SCAD;
        else
            b_sel_next = ppo_pkg::SEL_KEEP;
    end

    // divider load and restoring steps, one quotient bit per stage
    always_comb
    begin
        logic [DIV_W-1:0] divisor;
        logic [DIV_W:0]   trial;
        logic             next_bit;
        logic             fits;

        // scad rounds up: numerator gets den - 1 added
        scad_num  = {1'b0, b_gap_reg} + SCAD_NUM_W'(scad_den_reg) - SCAD_NUM_W'(1);
        ridge_num = {b_shift_reg, {FRAC_W{1'b0}}};
        unique case (b_sel_reg)
            ppo_pkg::SEL_RIDGE: div_num = NUM_WIDTH'(ridge_num);
            ppo_pkg::SEL_SCAD:  div_num = NUM_WIDTH'(scad_num);
            default:            div_num = '0;
        endcase

        div_valid_next[0] = b_valid_reg;
        div_sel_next[0]   = b_sel_reg;
        div_neg_next[0]   = b_neg_reg;
        div_rem_next[0]   = div_num[NUM_WIDTH-1:QUOT_WIDTH];
        div_bits_next[0]  = div_num[QUOT_WIDTH-1:0];
        unique case (b_sel_reg)
            ppo_pkg::SEL_ZERO:    div_direct_next[0] = '0;
            ppo_pkg::SEL_SHIFTED: div_direct_next[0] = b_shift_reg;
            default:              div_direct_next[0] = b_base_reg;
        endcase

        for (int i = 0; i < QUOT_WIDTH; i++)
        begin
            divisor  = (div_sel_reg[i] == ppo_pkg::SEL_RIDGE) ? ridge_div_reg
                                                               : DIV_W'(scad_den_reg);
            next_bit = div_bits_reg[i][QUOT_WIDTH-1];
            trial    = {div_rem_reg[i], next_bit} - {1'b0, divisor};
            fits     = !trial[DIV_W];
            div_rem_next[i+1]    = fits ? trial[DIV_W-1:0]
                                        : {div_rem_reg[i][DIV_W-2:0], next_bit};
            div_bits_next[i+1]   = {div_bits_reg[i][QUOT_WIDTH-2:0], fits};
            div_valid_next[i+1]  = div_valid_reg[i];
            div_sel_next[i+1]    = div_sel_reg[i];
            div_neg_next[i+1]    = div_neg_reg[i];
            div_direct_next[i+1] = div_direct_reg[i];
        end

        last_divisor = (div_sel_reg[QUOT_WIDTH] == ppo_pkg::SEL_RIDGE) ? ridge_div_reg
                                                                        : DIV_W'(scad_den_reg);
    end

    // stage f: pick the magnitude (quotient, m - quotient, or direct)
    always_comb
    begin
        quot         = div_bits_reg[QUOT_WIDTH][VALUE_WIDTH-1:0];
        f_valid_next = div_valid_reg[QUOT_WIDTH];
        f_pass_next  = div_sel_reg[QUOT_WIDTH] == ppo_pkg::SEL_PASS;
        f_neg_next   = div_neg_reg[QUOT_WIDTH];
        unique case (div_sel_reg[QUOT_WIDTH])
            ppo_pkg::SEL_RIDGE: f_mag_next = quot;
            ppo_pkg::SEL_SCAD:  f_mag_next = div_direct_reg[QUOT_WIDTH] - quot;
            default:            f_mag_next = div_direct_reg[QUOT_WIDTH];
        endcase
    end

    // output: restore sign, clamp negatives if asked
    // magnitudes never exceed the input magnitude, so no saturation is needed
    always_comb
    begin
        done_next = f_valid_reg;
        priority if (f_pass_reg)
            mapped_coefficient_next = f_mag_reg;
        else if (f_neg_reg && positive_only_reg)
            mapped_coefficient_next = '0;
        else if (f_neg_reg)
            mapped_coefficient_next = ~f_mag_reg + V_ONE;
        else
            mapped_coefficient_next = f_mag_reg;
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            for (int k = 0; k <= QUOT_WIDTH; k++)
            begin
                div_valid_reg[k] <= 1'b0;
            end
            f_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            for (int k = 0; k <= QUOT_WIDTH; k++)
            begin
                div_valid_reg[k] <= div_valid_next[k];
            end
            f_valid_reg <= f_valid_next;
            done_reg    <= done_next;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        a_value_reg <= a_value_next;
        a_pass_reg  <= a_pass_next;
        a_neg_reg   <= a_neg_next;
        a_mag_reg   <= a_mag_next;
        b_sel_reg   <= b_sel_next;
        b_neg_reg   <= b_neg_next;
        b_base_reg  <= b_base_next;
        b_shift_reg <= b_shift_next;
        b_gap_reg   <= b_gap_next;
        for (int k = 0; k <= QUOT_WIDTH; k++)
        begin
            div_sel_reg[k]    <= div_sel_next[k];
            div_neg_reg[k]    <= div_neg_next[k];
            div_direct_reg[k] <= div_direct_next[k];
            div_rem_reg[k]    <= div_rem_next[k];
            div_bits_reg[k]   <= div_bits_next[k];
        end
        f_pass_reg             <= f_pass_next;
        f_neg_reg              <= f_neg_next;
        f_mag_reg              <= f_mag_next;
        mapped_coefficient_reg <= mapped_coefficient_next;
    end

    assign busy               = busy_reg;
    assign done               = done_reg;
    assign mapped_coefficient = mapped_coefficient_reg;

    // every request yields exactly one result at the fixed latency
    `PPO_ASSERT_IMPLY(a_result_on_time, $past(start && !busy, RESULT_LATENCY), done, "request produced no result at the expected latency")
    `PPO_ASSERT_IMPLY(a_no_spurious_result, done, $past(start && !busy, RESULT_LATENCY), "result without a matching request")
    // unpenalized rows come out untouched
    `PPO_ASSERT_IMPLY(a_passthrough, $past(start && !busy && !penalized, RESULT_LATENCY), mapped_coefficient == $past(coefficient, RESULT_LATENCY), "unpenalized coefficient was altered")
    // the partial remainder leaving the divider is below the divisor
    `PPO_ASSERT_IMPLY(a_div_remainder, div_valid_reg[QUOT_WIDTH] && (div_sel_reg[QUOT_WIDTH] == ppo_pkg::SEL_RIDGE || div_sel_reg[QUOT_WIDTH] == ppo_pkg::SEL_SCAD), div_rem_reg[QUOT_WIDTH] < last_divisor, "divider remainder out of range")
    // clamp mode never emits a negative penalized result
    `PPO_ASSERT_NEXT(a_clamp_nonneg, f_valid_reg && !f_pass_reg && positive_only_reg, !mapped_coefficient[VALUE_WIDTH-1], "negative result with clamp enabled")

endmodule

// ===== verif/testbench.sv =====
module testbench;

    localparam int VW = 32;
    localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [ppo_pkg::REG_WIDTH-1:0] REG_MAX = '1;
    localparam logic [ppo_pkg::REG_WIDTH-1:0] Q_ONE = ppo_pkg::REG_WIDTH'(ppo_pkg::FRAC_ONE);
    localparam int DRAIN_CYCLES = 48;

    // expected mapped coefficients, predicted from a private copy of the registers
    class prox_map_predictor;
        ppo_pkg::penalty_kind_t        kind;
        logic [ppo_pkg::REG_WIDTH-1:0] threshold;
        logic [ppo_pkg::REG_WIDTH-1:0] ridge;
        logic [ppo_pkg::REG_WIDTH-1:0] shape;
        logic                          pos_only;
        logic [VW-1:0]                 expected_mapped[$];
        int unsigned                   mismatches;
        int unsigned                   checked;
        int unsigned                   passed_through;

        function new();
            kind       = ppo_pkg::KIND_ELASTIC;
            threshold  = '0;
            ridge      = '0;
            shape      = ppo_pkg::SHAPE_DEFAULT;
            pos_only   = 1'b0;
            mismatches = 0;
            checked    = 0;
            passed_through = 0;
        endfunction

        // register write, one-bit registers keep bit zero only
        function void write_reg(logic [ppo_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                logic [ppo_pkg::REG_WIDTH-1:0] data);
            case (idx)
                ppo_pkg::CFG_PENALTY_KIND:     kind = ppo_pkg::penalty_kind_t'(data[0]);
                ppo_pkg::CFG_SHRINK_THRESHOLD: threshold = data;
                ppo_pkg::CFG_RIDGE_AMOUNT:     ridge = data;
                ppo_pkg::CFG_SCAD_SHAPE:       shape = data;
                ppo_pkg::CFG_POSITIVE_ONLY:    pos_only = data[0];
                default: ;
            endcase
        endfunction

        function logic [VW-1:0] map_coefficient(logic [VW-1:0] v, logic pen);
            logic [63:0]   m, r, lim, t, a, at, gap, den, d, st;
            logic [VW-1:0] negv;
            logic          neg;
            t = 64'(threshold);
            // unpenalized row or no penalty at all: unchanged, no clamp
            if (!pen || (threshold == '0 && (kind == ppo_pkg::KIND_SCAD || ridge == '0)))
            begin
                passed_through++;
                return v;
            end
            neg  = v[VW-1];
            negv = -v;
            lim  = 64'd1 << (VW - 1);
            m    = neg ? 64'(negv) : 64'(v);
            if (kind == ppo_pkg::KIND_SCAD)
            begin
                // small shapes fall back to 3.7
                a = (shape <= ppo_pkg::SHAPE_MIN_RAW) ? 64'(ppo_pkg::SHAPE_DEFAULT)
                                                      : 64'(shape);
                if (m <= t)
                    r = 0;
                else if (m <= 2 * t)
                    r = m - t;
                else
                begin
                    at = a * t;
                    if (m <= (at >> ppo_pkg::FRAC_BITS))
                    begin
                        gap = at - m * 64'(ppo_pkg::FRAC_ONE);
                        den = a - 64'(ppo_pkg::SCAD_DEN_OFFSET);
                        r   = m - (gap + den - 1) / den;
                    end
                    else
                        r = m;
                end
            end
            else
            begin
                if (m <= t)
                    r = 0;
                else
                begin
                    st = m - t;
                    d  = 64'(ppo_pkg::FRAC_ONE) + 64'(ridge);
                    r  = (st / d) * 64'(ppo_pkg::FRAC_ONE)
                         + ((st % d) * 64'(ppo_pkg::FRAC_ONE)) / d;
                end
            end
            // restore sign, clamp, saturate
            if (neg)
            begin
                if (pos_only)
                    r = 0;
                if (r > lim)
                    r = lim;
                return -r[VW-1:0];
            end
            if (r > lim - 1)
                r = lim - 1;
            return r[VW-1:0];
        endfunction

        function void note_request(logic [VW-1:0] v, logic pen);
            expected_mapped = {expected_mapped, map_coefficient(v, pen)};
        endfunction

        function void check_result(logic [VW-1:0] got);
            logic [VW-1:0] want;
            if (expected_mapped.size() == 0)
            begin
                mismatches++;
                $error("mapped_coefficient: expected none, actual %0d", $signed(got));
                return;
            end
            want = expected_mapped.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                $error("mapped_coefficient: expected %0d, actual %0d",
                       $signed(want), $signed(got));
            end
        endfunction

        function int pending();
            return expected_mapped.size();
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic signed [VW-1:0]                coefficient;
    logic                                penalized;
    logic                                done;
    logic signed [VW-1:0]                mapped_coefficient;
    logic                                cfg_write;
    logic [ppo_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [ppo_pkg::REG_WIDTH-1:0]       cfg_data;

    prox_map_predictor sb = new();
    bit                gaps_on;
    int unsigned       n_requests;
    int unsigned       n_settings;

    penalized_proximal_operator_core #(
        .VALUE_WIDTH(VW)
    ) uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .coefficient        (coefficient),
        .penalized          (penalized),
        .done               (done),
        .mapped_coefficient (mapped_coefficient),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always #5 clk = ~clk;

    // results cannot be held off, take each one on its strobe
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(mapped_coefficient);
    end

    // one request; start stays high so back-to-back requests need not drop and raise it again
    task automatic send_request(input logic [VW-1:0] v, input logic pen);
        start       <= 1'b1;
        coefficient <= v;
        penalized   <= pen;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(v, pen);
        n_requests++;
        if (gaps_on && $urandom_range(0, 99) < 9)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    // hold off until every expected result is back
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [ppo_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [ppo_pkg::REG_WIDTH-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
    endtask

    // full register setting plus one stray write past the register list
    task automatic set_config(input logic [ppo_pkg::REG_WIDTH-1:0] kind_data,
                              input logic [ppo_pkg::REG_WIDTH-1:0] t,
                              input logic [ppo_pkg::REG_WIDTH-1:0] r,
                              input logic [ppo_pkg::REG_WIDTH-1:0] a,
                              input logic [ppo_pkg::REG_WIDTH-1:0] pos_data);
        write_reg(ppo_pkg::CFG_PENALTY_KIND, kind_data);
        write_reg(ppo_pkg::CFG_SHRINK_THRESHOLD, t);
        write_reg(ppo_pkg::CFG_RIDGE_AMOUNT, r);
        write_reg(ppo_pkg::CFG_SCAD_SHAPE, a);
        write_reg(ppo_pkg::CFG_POSITIVE_ONLY, pos_data);
        write_reg(ppo_pkg::CFG_INDEX_WIDTH'(ppo_pkg::CFG_POSITIVE_ONLY)
                  + ppo_pkg::CFG_INDEX_WIDTH'($urandom_range(1, 3)),
                  ppo_pkg::REG_WIDTH'($urandom));
        @(posedge clk);
        cfg_write <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [ppo_pkg::REG_WIDTH-1:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return REG_MAX;
            2:       return ppo_pkg::REG_WIDTH'($urandom_range(1, 255));
            3, 4:    return ppo_pkg::REG_WIDTH'($urandom >> $urandom_range(1, 31));
            default: return ppo_pkg::REG_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [ppo_pkg::REG_WIDTH-1:0] pick_shape();
        case ($urandom_range(0, 6))
            0:       return ppo_pkg::REG_WIDTH'($urandom_range(0, ppo_pkg::SHAPE_MIN_RAW));
            1:       return ppo_pkg::SHAPE_MIN_RAW;
            2:       return ppo_pkg::SHAPE_MIN_RAW + 1'b1;
            3:       return REG_MAX;
            4:       return ppo_pkg::REG_WIDTH'($urandom);
            5:       return ppo_pkg::SHAPE_DEFAULT;
            default: return ppo_pkg::REG_WIDTH'($urandom_range(ppo_pkg::SHAPE_MIN_RAW + 1,
                                                               10 * ppo_pkg::FRAC_ONE));
        endcase
    endfunction

    // coefficients aimed at the zone edges of the current setting
    function automatic logic [VW-1:0] pick_coefficient();
        logic [63:0] t, a, knee, mag;
        logic        neg;
        t    = 64'(sb.threshold);
        a    = (sb.shape <= ppo_pkg::SHAPE_MIN_RAW) ? 64'(ppo_pkg::SHAPE_DEFAULT)
                                                    : 64'(sb.shape);
        knee = (a * t) >> ppo_pkg::FRAC_BITS;
        case ($urandom_range(0, 9))
            0:       mag = 64'($urandom_range(0, 3));
            1:       mag = 64'(VAL_MIN) - 64'($urandom_range(0, 2));
            2:       mag = t - (t * 64'($urandom_range(0, 100))) / 100;
            3:       mag = t + 64'($urandom_range(0, 8)) - 4;
            4:       mag = 2 * t + 64'($urandom_range(0, 8)) - 4;
            5:       mag = 2 * t + ((knee - 2 * t) * 64'($urandom_range(0, 100))) / 100;
            6:       mag = knee + 64'($urandom_range(0, 8)) - 4;
            7:       return VW'($urandom);
            default: mag = 64'($urandom >> $urandom_range(0, 31));
        endcase
        if (mag > 64'(VAL_MIN))
            mag = 64'($urandom) >> 1;
        neg = 1'($urandom_range(0, 1));
        if (!neg && mag == 64'(VAL_MIN))
            mag = 64'(VAL_MAX);
        return neg ? -mag[VW-1:0] : mag[VW-1:0];
    endfunction

    initial
    begin
        int unsigned n_items;
        rst_n       = 1'b0;
        start       = 1'b0;
        coefficient = '0;
        penalized   = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        gaps_on     = 1'b0;
        n_requests  = 0;
        n_settings  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: elastic net with no penalty passes through
        send_request(VAL_MAX, 1'b1);
        send_request(VAL_MIN, 1'b1);
        drain();

        // elastic net at threshold one, ridge one; kind and clamp written with upper bits set
        set_config(31'd2, Q_ONE, Q_ONE, ppo_pkg::SHAPE_DEFAULT, 31'h7FFF_FFFE);
        send_request('0, 1'b1);
        send_request(VW'(ppo_pkg::FRAC_ONE), 1'b1);
        send_request(VW'(ppo_pkg::FRAC_ONE) + 1'b1, 1'b1);
        send_request(-(VW'(ppo_pkg::FRAC_ONE) + 1'b1), 1'b1);
        send_request(VAL_MAX, 1'b1);
        send_request(VAL_MIN, 1'b1);
        send_request(VW'(32'h1234_5678), 1'b0);
        drain();

        // scad with a too-small shape, clamp on: hit every zone edge
        set_config(ppo_pkg::REG_WIDTH'(ppo_pkg::KIND_SCAD), Q_ONE, '0, '0, 31'd1);
        send_request(VW'(ppo_pkg::FRAC_ONE), 1'b1);
        send_request(VW'(2 * ppo_pkg::FRAC_ONE), 1'b1);
        send_request(VW'(2 * ppo_pkg::FRAC_ONE) + 1'b1, 1'b1);
        send_request(VW'(ppo_pkg::SHAPE_DEFAULT), 1'b1);
        send_request(VW'(ppo_pkg::SHAPE_DEFAULT) + 1'b1, 1'b1);
        send_request(-VW'(3 * ppo_pkg::FRAC_ONE), 1'b1);
        send_request(VAL_MAX, 1'b1);
        send_request(VAL_MIN, 1'b1);
        send_request(-VW'(5), 1'b0);
        drain();

        // scad without threshold passes through
        set_config(ppo_pkg::REG_WIDTH'(ppo_pkg::KIND_SCAD), '0, REG_MAX,
                   ppo_pkg::SHAPE_DEFAULT, '0);
        send_request(VW'(12345), 1'b1);
        drain();

        // elastic net with ridge only, largest ridge
        set_config(ppo_pkg::REG_WIDTH'(ppo_pkg::KIND_ELASTIC), '0, REG_MAX,
                   ppo_pkg::SHAPE_DEFAULT, '0);
        send_request(VAL_MAX, 1'b1);
        send_request(VAL_MIN, 1'b1);
        drain();

        // scad at the largest threshold and shape
        set_config(ppo_pkg::REG_WIDTH'(ppo_pkg::KIND_SCAD), REG_MAX, '0, REG_MAX, '0);
        send_request(VAL_MAX, 1'b1);
        send_request(VAL_MIN, 1'b1);
        send_request('1, 1'b1);
        drain();

        // random settings, random requests; a stretch of phases runs without gaps
        for (int p = 0; p < 30; p++)
        begin
            set_config(ppo_pkg::REG_WIDTH'($urandom), pick_reg_value(), pick_reg_value(),
                       pick_shape(), ppo_pkg::REG_WIDTH'($urandom));
            gaps_on = (p < 10 || p > 14);
            n_items = $urandom_range(35, 65);
            for (int i = 0; i < n_items; i++)
                send_request(pick_coefficient(), 1'($urandom_range(0, 99) < 85));
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d requests over %0d register settings (%0d passed through)",
                 n_requests, n_settings, sb.passed_through);
        $display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // hang guard
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
